// ===== design/qslerp_pkg.sv =====
// shared constants, types and tables for the quaternion slerp pipeline
package qslerp_pkg;

  localparam int COMP_W  = 16;
  localparam int COMP_FB = COMP_W - 2;
  localparam int FRAC_W  = 16;
  localparam int THR_W   = 17;

  localparam logic [THR_W-1:0]  THR_RESET = 17'd65529;
  localparam logic [THR_W-1:0]  THR_MAX   = 17'd65536;
  localparam logic [FRAC_W:0]   FRAC_ONE  = 17'd65536;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 64;

  localparam int CORDIC_N = 30;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [63:0] ONE60 = 64'h1000_0000_0000_0000;

  localparam logic [29:0] ATAN_TAB [CORDIC_N] = '{
    30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535,
    30'd32767, 30'd16383, 30'd8191, 30'd4095, 30'd2047,
    30'd1023, 30'd511, 30'd255, 30'd127, 30'd63,
    30'd31, 30'd15, 30'd8, 30'd4, 30'd2
  };

  // iterative units
  localparam int SQRT_LAT  = 32;
  localparam int DIV_LAT   = 32;
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_QUO_W = 31;
  localparam int DIV_REM_W = 63;

  // stage numbers, counted in registers from the input
  localparam int P_DOT   = 2;
  localparam int P_SQ    = 3;
  localparam int P_S30   = P_SQ + SQRT_LAT;
  localparam int P_OMEGA = P_S30 + CORDIC_N;
  localparam int P_ANG   = P_OMEGA + 1;
  localparam int P_SIN   = P_ANG + CORDIC_N;
  localparam int P_WDIV  = P_SIN + DIV_LAT;
  localparam int P_W     = P_WDIV + 1;
  localparam int P_PROD  = P_W + 1;
  localparam int P_MAG   = P_PROD + 1;
  localparam int P_LEAD  = P_MAG + 1;
  localparam int P_NORM  = P_LEAD + 1;
  localparam int P_SQR   = P_NORM + 1;
  localparam int P_SUM   = P_SQR + 1;
  localparam int P_LEN   = P_SUM + SQRT_LAT;
  localparam int P_QUO   = P_LEN + DIV_LAT;
  localparam int P_OUT   = P_QUO + 1;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cord_t;

  typedef struct packed {
    logic [3:0][COMP_W-1:0] p;
    logic [3:0][COMP_W-1:0] q;
    logic [FRAC_W:0]        f;
    logic                   neg;
    logic                   lin;
  } side_t;

endpackage

// ===== design/quaternion_slerp_top.sv =====
// quaternion slerp top level: fixed-point pipelined blend and normalize
// throughput: one item per cycle; the whole pipeline holds while the output stalls
// depth is set by two 32-stage square roots, three 30-stage cordics and 32-stage dividers
// reset clears all valid bits and loads the threshold register thr_q with 65529
module quaternion_slerp_top import qslerp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [THR_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // p_x, p_y, p_z, p_w, q_x, q_y, q_z, q_w, fraction, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]            m_axis_tuser
);

  logic                en;
  logic [P_OUT:1]      vld_q;
  logic [THR_W-1:0]    thr_q;

  assign en            = !vld_q[P_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[P_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      thr_q <= THR_RESET;
    end else begin
      if (en) begin
        vld_q <= {vld_q[P_OUT-1:1], s_axis_tvalid};
      end
      if (cfg_we_i) begin
        thr_q <= (cfg_wdata_i > THR_MAX) ? THR_MAX : cfg_wdata_i;
      end
    end
  end

  // input unpack and products
  logic [3:0][COMP_W-1:0]      in_p, in_q;
  logic [FRAC_W:0]             in_f, fc;
  logic signed [2*COMP_W-1:0]  prod_q [4];
  logic [3:0][COMP_W-1:0]      p1_q, q1_q;
  logic [FRAC_W:0]             f1_q;

  assign in_p = s_axis_tdata[4*COMP_W-1:0];
  assign in_q = s_axis_tdata[8*COMP_W-1:4*COMP_W];
  assign in_f = s_axis_tdata[8*COMP_W+FRAC_W:8*COMP_W];
  assign fc   = (in_f > FRAC_ONE) ? FRAC_ONE : in_f;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= $signed(in_p[i]) * $signed(in_q[i]);
      end
      p1_q <= in_p;
      q1_q <= in_q;
      f1_q <= fc;
    end
  end

  // dot product, threshold test
  logic signed [31:0] dot_c;
  logic        [31:0] mag_c;
  logic        [35:0] cos_c;
  logic               lin_c;
  logic        [29:0] cosc_c, cosc2_q;
  side_t              side_q [P_DOT:P_W];

  always_comb begin
    dot_c  = (prod_q[0] >>> 2) + (prod_q[1] >>> 2) + (prod_q[2] >>> 2) + (prod_q[3] >>> 2);
    mag_c  = dot_c[31] ? 32'(-dot_c) : 32'(dot_c);
    cos_c  = {mag_c, 4'b0};
    lin_c  = cos_c >= {5'b0, thr_q, 14'b0};
    cosc_c = lin_c ? '0 : cos_c[29:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[P_DOT] <= '{p: p1_q, q: q1_q, f: f1_q, neg: dot_c[31], lin: lin_c};
      cosc2_q       <= cosc_c;
      for (int s = P_DOT + 1; s <= P_W; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // sin(omega) = sqrt(1 - cos^2)
  logic [59:0] sq_q;
  logic [29:0] cos_q [P_SQ:P_S30];
  logic [31:0] s30_w;
  logic [30:0] s30_q [P_S30+1:P_SIN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q        <= 60'(cosc2_q) * 60'(cosc2_q);
      cos_q[P_SQ] <= cosc2_q;
      for (int s = P_SQ + 1; s <= P_S30; s++) begin
        cos_q[s] <= cos_q[s-1];
      end
      s30_q[P_S30+1] <= s30_w[30:0];
      for (int s = P_S30 + 2; s <= P_SIN; s++) begin
        s30_q[s] <= s30_q[s-1];
      end
    end
  end

  qslerp_sqrt u_sqrt_sin (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (ONE60 - {4'b0, sq_q}),
    .root_o (s30_w)
  );

  // omega by cordic vectoring
  cord_t vec_q [P_S30+1:P_OMEGA];

  for (genvar k = 0; k < CORDIC_N; k++) begin : g_vec
    cord_t cin, cnx;
    if (k == 0) begin : g_first
      assign cin.x = $signed({4'b0, cos_q[P_S30]});
      assign cin.y = $signed({3'b0, s30_w[30:0]});
      assign cin.z = '0;
    end else begin : g_next
      assign cin = vec_q[P_S30+k];
    end

    always_comb begin
      if (cin.y > 0) begin
        cnx.x = cin.x + (cin.y >>> k);
        cnx.y = cin.y - (cin.x >>> k);
        cnx.z = cin.z + $signed({3'b0, ATAN_TAB[k]});
      end else begin
        cnx.x = cin.x - (cin.y >>> k);
        cnx.y = cin.y + (cin.x >>> k);
        cnx.z = cin.z - $signed({3'b0, ATAN_TAB[k]});
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        vec_q[P_S30+1+k] <= cnx;
      end
    end
  end

  // blend angles
  logic [30:0]    omega_c, ap_q, aq_q;
  logic [FRAC_W:0] fom_c, fpm_c;
  logic [47:0]    ap_c, aq_c;

  always_comb begin
    omega_c = vec_q[P_OMEGA].z[32] ? '0 : vec_q[P_OMEGA].z[30:0];
    fom_c   = side_q[P_OMEGA].f;
    fpm_c   = FRAC_ONE - fom_c;
    ap_c    = 48'(omega_c) * 48'(fpm_c);
    aq_c    = 48'(omega_c) * 48'(fom_c);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ap_q <= ap_c[46:16];
      aq_q <= aq_c[46:16];
    end
  end

  // sines by cordic rotation, one lane per weight
  cord_t rot_q [2][P_ANG+1:P_SIN];

  for (genvar c = 0; c < 2; c++) begin : g_lane
    for (genvar k = 0; k < CORDIC_N; k++) begin : g_rot
      cord_t cin, cnx;
      if (k == 0) begin : g_first
        assign cin.x = CORDIC_X0;
        assign cin.y = '0;
        assign cin.z = (c == 0) ? $signed({2'b0, ap_q}) : $signed({2'b0, aq_q});
      end else begin : g_next
        assign cin = rot_q[c][P_ANG+k];
      end

      always_comb begin
        if (cin.z >= 0) begin
          cnx.x = cin.x - (cin.y >>> k);
          cnx.y = cin.y + (cin.x >>> k);
          cnx.z = cin.z - $signed({3'b0, ATAN_TAB[k]});
        end else begin
          cnx.x = cin.x + (cin.y >>> k);
          cnx.y = cin.y - (cin.x >>> k);
          cnx.z = cin.z + $signed({3'b0, ATAN_TAB[k]});
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          rot_q[c][P_ANG+1+k] <= cnx;
        end
      end
    end
  end

  // spherical weights sin(angle) / sin(omega)
  logic [DIV_QUO_W-1:0] wquo [2];
  logic                 wovf [2];
  logic [30:0]          wsph [2];

  for (genvar c = 0; c < 2; c++) begin : g_wdiv
    logic [31:0] sc;
    assign sc = rot_q[c][P_SIN].y[33] ? '0 : rot_q[c][P_SIN].y[31:0];

    qslerp_div u_div_w (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({sc, 30'b0}),
      .den_i ({1'b0, s30_q[P_SIN]}),
      .quo_o (wquo[c]),
      .ovf_o (wovf[c])
    );

    assign wsph[c] = (wovf[c] || wquo[c] > ONE30) ? ONE30 : wquo[c];
  end

  // weight select
  logic [30:0]        wp_c, wq_c, wp_q;
  logic signed [31:0] wqs_q;
  logic               linw_q;
  logic [FRAC_W:0]    fw_c;

  always_comb begin
    fw_c = side_q[P_WDIV].f;
    if (side_q[P_WDIV].lin) begin
      wp_c = 31'(FRAC_ONE - fw_c) << (30 - FRAC_W);
      wq_c = 31'(fw_c) << (30 - FRAC_W);
    end else begin
      wp_c = wsph[0];
      wq_c = wsph[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wp_q   <= wp_c;
      wqs_q  <= side_q[P_WDIV].neg ? -$signed({1'b0, wq_c}) : $signed({1'b0, wq_c});
      linw_q <= side_q[P_WDIV].lin;
    end
  end

  // weighted sum
  logic signed [47:0] pw_q [4];
  logic signed [47:0] qw_q [4];
  logic signed [48:0] r_c [4];
  logic [47:0]        mag_q [4];
  logic [47:0]        mag2_q [4];
  logic [4:0]         sgn_c;
  logic [4:0]         sgn_q [P_MAG:P_QUO];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pw_q[i] <= $signed({1'b0, wp_q}) * $signed(side_q[P_W].p[i]);
        qw_q[i] <= wqs_q * $signed(side_q[P_W].q[i]);
      end
    end
  end

  always_comb begin
    sgn_c[4] = 1'b1;
    for (int i = 0; i < 4; i++) begin
      r_c[i]   = $signed({pw_q[i][47], pw_q[i]}) + $signed({qw_q[i][47], qw_q[i]});
      sgn_c[i] = r_c[i][48];
      if (r_c[i] != 0) begin
        sgn_c[4] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mag_q[i] <= r_c[i][48] ? 48'(-r_c[i]) : r_c[i][47:0];
      end
      sgn_q[P_MAG] <= sgn_c;
      for (int s = P_MAG + 1; s <= P_QUO; s++) begin
        sgn_q[s] <= sgn_q[s-1];
      end
    end
  end

  // leading one of the largest magnitude
  logic [47:0] orw_c;
  logic [5:0]  lead_c, lead_q;

  always_comb begin
    orw_c  = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
    lead_c = '0;
    for (int b = 0; b < 48; b++) begin
      if (orw_c[b]) begin
        lead_c = 6'(b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lead_q <= lead_c;
      mag2_q <= mag_q;
    end
  end

  // scale so the largest lies in [2^29, 2^30)
  logic [3:0][29:0] mn_c;
  logic [3:0][29:0] mn_q [P_NORM:P_LEN];
  logic [47:0]      sh_c [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (lead_q >= 6'd29) begin
        sh_c[i] = mag2_q[i] >> (lead_q - 6'd29);
      end else begin
        sh_c[i] = mag2_q[i] << (6'd29 - lead_q);
      end
      mn_c[i] = sh_c[i][29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mn_q[P_NORM] <= mn_c;
      for (int s = P_NORM + 1; s <= P_LEN; s++) begin
        mn_q[s] <= mn_q[s-1];
      end
    end
  end

  // length
  logic [59:0] sqr_q [4];
  logic [61:0] sum_q;
  logic [31:0] len_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sqr_q[i] <= 60'(mn_q[P_SQR-1][i]) * 60'(mn_q[P_SQR-1][i]);
      end
      sum_q <= 62'(sqr_q[0]) + 62'(sqr_q[1]) + 62'(sqr_q[2]) + 62'(sqr_q[3]);
    end
  end

  qslerp_sqrt u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({2'b0, sum_q}),
    .root_o (len_w)
  );

  // normalize, round, saturate
  logic [DIV_QUO_W-1:0] oquo [4];
  logic [3:0][15:0]     out_c, out_q;
  logic                 deg_q;

  for (genvar i = 0; i < 4; i++) begin : g_norm
    logic        ovf_unused;
    logic [30:0] lim, oc;

    qslerp_div u_div_o (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ((DIV_NUM_W'(mn_q[P_LEN][i]) << COMP_FB) + DIV_NUM_W'(len_w >> 1)),
      .den_i (len_w),
      .quo_o (oquo[i]),
      .ovf_o (ovf_unused)
    );

    always_comb begin
      lim = sgn_q[P_QUO][i] ? 31'd32768 : 31'd32767;
      oc  = (oquo[i] > lim) ? lim : oquo[i];
      if (sgn_q[P_QUO][4]) begin
        out_c[i] = '0;
      end else if (sgn_q[P_QUO][i]) begin
        out_c[i] = -oc[15:0];
      end else begin
        out_c[i] = oc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_c;
      deg_q <= sgn_q[P_QUO][4];
    end
  end

  assign m_axis_tdata = out_q;
  assign m_axis_tuser = deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero components");

  a_thr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q <= THR_MAX)
    else $error("threshold register above one");

  a_lin_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P_W] && linw_q |->
      (33'(wp_q) + 33'(wqs_q[31] ? -wqs_q : wqs_q)) == 33'(ONE30))
    else $error("linear weights do not sum to one");

endmodule

// ===== design/qslerp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module qslerp_sqrt import qslerp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  logic [63:0] v_q [SQRT_LAT-1];
  logic [63:0] r_q [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] vin, rin, vnx, rnx, t;

    if (k == 0) begin : g_first
      assign vin = rad_i;
      assign rin = '0;
    end else begin : g_next
      assign vin = v_q[k-1];
      assign rin = r_q[k-1];
    end

    always_comb begin
      t = rin + BIT;
      if (vin >= t) begin
        vnx = vin - t;
        rnx = (rin >> 1) + BIT;
      end else begin
        vnx = vin;
        rnx = rin >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= rnx;
      end
    end

    if (k < SQRT_LAT - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[k] <= vnx;
        end
      end
    end
  end

  assign root_o = r_q[SQRT_LAT-1][31:0];

endmodule

// ===== design/qslerp_div.sv =====
// pipelined restoring divider with overflow flag; the first stage sets the flag, then one quotient bit per stage
module qslerp_div import qslerp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_QUO_W-1:0] quo_o,
  output logic                 ovf_o
);

  logic [DIV_REM_W-1:0] rem_q [DIV_LAT-1];
  logic [DIV_DEN_W-1:0] den_q [DIV_LAT-1];
  logic [DIV_QUO_W-1:0] quo_q [DIV_LAT];
  logic                 ovf_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DIV_REM_W'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= DIV_REM_W'(num_i) >= {den_i, {DIV_QUO_W{1'b0}}};
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    localparam int B = DIV_QUO_W - k;
    logic [DIV_REM_W-1:0] sub, rnx;
    logic [DIV_QUO_W-1:0] qnx;

    always_comb begin
      sub = DIV_REM_W'(den_q[k-1]) << B;
      if (rem_q[k-1] >= sub) begin
        rnx = rem_q[k-1] - sub;
        qnx = quo_q[k-1] | (DIV_QUO_W'(1) << B);
      end else begin
        rnx = rem_q[k-1];
        qnx = quo_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= qnx;
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < DIV_LAT - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rnx;
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];
  assign ovf_o = ovf_q[DIV_LAT-1];

endmodule
